// File: hw/rtl/uuls_pkg.sv
`default_nettype none

package uuls_pkg;

  // Characters that steer the line parser.
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MASK7 = 8'h7F;

  // One accepted input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       stream_done;
  } out_word_t;

  // What the front hands to the back for one input: up to two decoded groups,
  // each with the number of its bytes that survive the line count.
  typedef struct packed {
    logic [23:0] a_bits;
    logic [1:0]  a_cnt;
    logic [23:0] b_bits;
    logic [1:0]  b_cnt;
    logic        eod;
  } entry_t;

  // ASCII upper case letters fold to lower case, everything else stays.
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c | 8'h20;
    end
    return r;
  endfunction

  // Characters of the "begin " prefix by position.
  function automatic logic [7:0] begin_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = 8'h62;
      3'd1: r = 8'h65;
      3'd2: r = 8'h67;
      3'd3: r = 8'h69;
      3'd4: r = 8'h6E;
      3'd5: r = 8'h20;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Characters of the "end" prefix by position.
  function automatic logic [7:0] end_char(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'h65;
      2'd1: r = 8'h6E;
      2'd2: r = 8'h64;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Byte of a decoded group, most significant first.
  function automatic logic [7:0] group_byte(input logic [23:0] bits, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = bits[23:16];
      2'd1: r = bits[15:8];
      2'd2: r = bits[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/uuls_front.sv
`default_nettype none

module uuls_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic              full,
  input  wire uuls_pkg::in_word_t in_word,
  output logic                   q_push,
  output uuls_pkg::entry_t       q_entry
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        begin_ok_r, begin_ok_nxt;
  logic        end_ok_r, end_ok_nxt;
  logic [6:0]  count_r, count_nxt;
  logic [6:0]  emitted_r, emitted_nxt;
  logic [23:0] gbits_r, gbits_nxt;
  logic [1:0]  gchars_r, gchars_nxt;
  logic [23:0] held_r, held_nxt;
  logic        held_v_r, held_v_nxt;

  logic        accept;
  logic [7:0]  c;
  logic [7:0]  fc;
  logic [7:0]  cdiff;
  logic [2:0]  p;
  logic        is_brk;
  logic        eod;
  logic        a_go;
  logic [23:0] a_bits;
  logic        b_go;
  logic [23:0] b_bits;
  logic [1:0]  ka;
  logic [1:0]  kb;

  // Bytes of a group still allowed by the line count, at most three.
  function automatic logic [1:0] take3(input logic [6:0] avail);
    return (avail >= 7'd3) ? 2'd3 : avail[1:0];
  endfunction

  assign accept = push && !full;

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    begin_ok_nxt = begin_ok_r;
    end_ok_nxt   = end_ok_r;
    count_nxt    = count_r;
    emitted_nxt  = emitted_r;
    gbits_nxt    = gbits_r;
    gchars_nxt   = gchars_r;
    held_nxt     = held_r;
    held_v_nxt   = held_v_r;
    a_go   = 1'b0;
    a_bits = '0;
    b_go   = 1'b0;
    b_bits = '0;
    ka     = 2'd0;
    kb     = 2'd0;

    c      = in_word.data_byte;
    eod    = in_word.end_of_data;
    fc     = uuls_pkg::fold(c);
    cdiff  = c - uuls_pkg::CHAR_SPACE;
    p      = pos_r;
    is_brk = (c == uuls_pkg::CHAR_CR) || (c == uuls_pkg::CHAR_LF);

    if (is_brk) begin
      // The line end itself is handled below.
    end else if (phase_r == PH_IDLE) begin
      // Count character opens a new line.
      pos_nxt      = 3'd1;
      begin_ok_nxt = (fc == uuls_pkg::begin_char(3'd0));
      end_ok_nxt   = (fc == uuls_pkg::end_char(2'd0));
      emitted_nxt  = '0;
      gbits_nxt    = '0;
      gchars_nxt   = '0;
      held_nxt     = '0;
      held_v_nxt   = 1'b0;
      if ((c & uuls_pkg::CHAR_MASK7) < uuls_pkg::CHAR_SPACE) begin
        count_nxt = '0;
        phase_nxt = PH_SKIP;
      end else begin
        count_nxt = {1'b0, cdiff[5:0]};
        phase_nxt = PH_DATA;
      end
    end else if (phase_r == PH_DATA) begin
      if (p < 3'd6 && fc != uuls_pkg::begin_char(p)) begin
        begin_ok_nxt = 1'b0;
      end
      if (p < 3'd3 && fc != uuls_pkg::end_char(p[1:0])) begin
        end_ok_nxt = 1'b0;
      end
      if (pos_r != 3'd7) begin
        pos_nxt = pos_r + 3'd1;
      end
      if (p == 3'd2 && end_ok_nxt) begin
        phase_nxt = PH_SKIP;
      end else if (p == 3'd5 && begin_ok_nxt) begin
        held_v_nxt = 1'b0;
        held_nxt   = '0;
        phase_nxt  = PH_SKIP;
      end else begin
        if (p == 3'd5 && held_v_nxt) begin
          a_go       = 1'b1;
          a_bits     = held_nxt;
          held_v_nxt = 1'b0;
          held_nxt   = '0;
        end
        gbits_nxt = {gbits_nxt[17:0], cdiff[5:0]};
        if (gchars_nxt == 2'd3) begin
          if (begin_ok_nxt && p < 3'd5) begin
            held_nxt   = gbits_nxt;
            held_v_nxt = 1'b1;
          end else begin
            a_go   = 1'b1;
            a_bits = gbits_nxt;
          end
          gbits_nxt  = '0;
          gchars_nxt = '0;
        end else begin
          gchars_nxt = gchars_nxt + 2'd1;
        end
      end
    end

    if (a_go) begin
      ka = take3(count_nxt - emitted_nxt);
    end
    emitted_nxt = emitted_nxt + {5'd0, ka};

    if (is_brk || eod) begin
      // A held group and an open partial group never coexist at a line end.
      if (phase_nxt == PH_DATA) begin
        if (held_v_nxt) begin
          b_go   = 1'b1;
          b_bits = held_nxt;
        end else if (gchars_nxt != 2'd0) begin
          b_go = 1'b1;
          case (gchars_nxt)
            2'd1:    b_bits = {gbits_nxt[5:0], 18'd0};
            2'd2:    b_bits = {gbits_nxt[11:0], 12'd0};
            2'd3:    b_bits = {gbits_nxt[17:0], 6'd0};
            default: b_bits = '0;
          endcase
        end
      end
      if (b_go) begin
        kb = take3(count_nxt - emitted_nxt);
      end
      phase_nxt    = PH_IDLE;
      pos_nxt      = '0;
      begin_ok_nxt = 1'b1;
      end_ok_nxt   = 1'b1;
      count_nxt    = '0;
      emitted_nxt  = '0;
      gbits_nxt    = '0;
      gchars_nxt   = '0;
      held_nxt     = '0;
      held_v_nxt   = 1'b0;
    end
  end

  assign q_push         = accept && (ka != 2'd0 || kb != 2'd0 || eod);
  assign q_entry.a_bits = a_bits;
  assign q_entry.a_cnt  = ka;
  assign q_entry.b_bits = b_bits;
  assign q_entry.b_cnt  = kb;
  assign q_entry.eod    = eod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      pos_r      <= '0;
      begin_ok_r <= 1'b1;
      end_ok_r   <= 1'b1;
      count_r    <= '0;
      emitted_r  <= '0;
      gbits_r    <= '0;
      gchars_r   <= '0;
      held_r     <= '0;
      held_v_r   <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      begin_ok_r <= begin_ok_nxt;
      end_ok_r   <= end_ok_nxt;
      count_r    <= count_nxt;
      emitted_r  <= emitted_nxt;
      gbits_r    <= gbits_nxt;
      gchars_r   <= gchars_nxt;
      held_r     <= held_nxt;
      held_v_r   <= held_v_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/uuls_queue.sv
`default_nettype none

module uuls_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire uuls_pkg::entry_t wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output uuls_pkg::entry_t      rd_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  uuls_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr);
    return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (rd_en) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/uuls_back.sv
`default_nettype none

module uuls_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire uuls_pkg::entry_t q_head,
  output logic                  q_pop,
  output logic                  empty,
  input  wire logic             pop,
  output uuls_pkg::out_word_t   out_word
);

  logic [2:0]          idx_r, idx_nxt;
  logic                ov_r;
  uuls_pkg::out_word_t word_r;
  uuls_pkg::out_word_t word_nxt;

  logic [2:0] total;
  logic [2:0] nwords;
  logic [2:0] b_idx;
  logic       last;
  logic       load;
  logic       out_take;
  logic [7:0] sel_byte;

  assign total  = {1'b0, q_head.a_cnt} + {1'b0, q_head.b_cnt};
  assign nwords = (total == 3'd0) ? 3'd1 : total;
  assign last   = (idx_r == nwords - 3'd1);
  assign b_idx  = idx_r - {1'b0, q_head.a_cnt};

  always_comb begin
    if (idx_r < {1'b0, q_head.a_cnt}) begin
      sel_byte = uuls_pkg::group_byte(q_head.a_bits, idx_r[1:0]);
    end else begin
      sel_byte = uuls_pkg::group_byte(q_head.b_bits, b_idx[1:0]);
    end
  end

  always_comb begin
    word_nxt.out_byte    = (total != 3'd0) ? sel_byte : 8'h00;
    word_nxt.byte_valid  = (total != 3'd0);
    word_nxt.last_of_run = last;
    word_nxt.stream_done = last && q_head.eod;
  end

  assign out_take = pop && ov_r;
  assign load     = !q_empty && (!ov_r || out_take);
  assign q_pop    = load && last;
  assign idx_nxt  = last ? 3'd0 : idx_r + 3'd1;
  assign empty    = !ov_r;
  assign out_word = word_r;

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= idx_nxt;
        ov_r  <= 1'b1;
      end else if (out_take) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/uudecode_line_stream.sv
// Path: an accepted word's result is registered first in the entry queue, then in the output register.
// Throughput: one input word per cycle while full is low, and one result word per cycle
// while pop is high and the queue holds an entry; push stalls (full) only while the entry
// queue between front and back holds QUEUE_DEPTH entries.
// Reset: synchronous on rst_n low; line state returns to "between lines", the queue and
// the output register are emptied.
`default_nettype none

module uudecode_line_stream #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire uuls_pkg::in_word_t  in_word,
  output logic                     empty,
  input  wire logic                pop,
  output uuls_pkg::out_word_t      out_word
);

  // The front runs the line parser combinationally on every accepted word. It
  // tracks the count character, the "begin " and "end" prefix checks, the open
  // six-bit group and the first group, which is held until the "begin " check is
  // settled. Each word can release at most two groups: one from the character
  // itself and one from the line end that a CR, LF or end_of_data causes. The
  // count limit is already applied here, so an entry carries each group together
  // with the number of its bytes that go out.
  logic             q_push;
  logic             q_pop;
  logic             q_empty;
  uuls_pkg::entry_t q_wr;
  uuls_pkg::entry_t q_head;

  uuls_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .q_push  (q_push),
    .q_entry (q_wr)
  );

  // The queue decouples the two sides: the front keeps taking a word per cycle, unless the
  // queue is full, while the back still walks an earlier entry that yields up to six bytes.
  // Words that produce no result never enter it.
  uuls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  // The back walks the head entry one byte per cycle into the output register while pop takes each word.
  // An entry with no bytes (end of data alone) becomes a single marker word.
  // The output register refills in the same cycle that its word is popped.
  uuls_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

`ifndef SYNTHESIS
  // A word without a decoded byte only ever marks the end of the text.
  a_marker_is_done : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_word.byte_valid) |->
      (out_word.stream_done && out_word.last_of_run && out_word.out_byte == 8'h00))
    else $error("marker word without stream_done or with a byte");

  // The end of the text always closes the run of the input that caused it.
  a_done_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_word.stream_done) |-> out_word.last_of_run)
    else $error("stream_done without last_of_run");

  // After reset both sides start empty.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queue or output not empty after reset");
`endif

endmodule

`default_nettype wire
